// File: hdl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg: shared types and constants of the sequence reorder queue
// Holds the command and status codes and the default sizes of the queue.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned DATA_BITS_DEF = 32;
  localparam int unsigned SEQ_BITS_DEF  = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_WINDOW   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_CLOSED   = 3'd3,
    ST_OCCUPIED = 3'd4
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    item_valid;
  } res_ctl_t;

endpackage

// File: hdl/rqs_ram.sv
// ----------------------------------------------------------------------------
// rqs_ram: slot store of the sequence reorder queue
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rqs_ram #(
  parameter int unsigned DEPTH = rqs_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = rqs_pkg::DATA_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/reorder_queue_by_sequence_top.sv
// ----------------------------------------------------------------------------
// reorder_queue_by_sequence_top: reorder buffer keyed by sequence number
// Pushes store tagged payloads in a window of DEPTH slots from the head; pops
// hand out the head payload in sequence order; close stops further pushes.
// ----------------------------------------------------------------------------
// The queue takes one command word per clock cycle unless the pipeline stalls
// and returns exactly one result word per command from its output register.
// Each command reads one slot of the slot memory in its first stage and is
// decided and written back in its second, with the last write forwarded to
// the next command. A result word held by a low out_tready stalls the whole
// pipeline, and in_tready then drops once the input register is occupied.
// After reset the slot memory is cleared one slot per cycle, and in_tready
// stays low until that pass is complete.
module reorder_queue_by_sequence_top #(
  parameter int unsigned DEPTH     = rqs_pkg::DEPTH_DEF,
  parameter int unsigned DATA_BITS = rqs_pkg::DATA_BITS_DEF,
  parameter int unsigned SEQ_BITS  = rqs_pkg::SEQ_BITS_DEF,
  localparam int unsigned IN_W  =
    ((rqs_pkg::CMD_W + SEQ_BITS + DATA_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W =
    ((rqs_pkg::STATUS_W + 1 + DATA_BITS + SEQ_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command, seq_tag, payload
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, item_valid, item_data, item_tag
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CW    = (SEQ_BITS > IDX_W + 1) ? SEQ_BITS : IDX_W + 1;
  localparam int unsigned WORD_W = DATA_BITS + 1;
  localparam int unsigned TAG_LO = rqs_pkg::CMD_W;
  localparam int unsigned PAY_LO = rqs_pkg::CMD_W + SEQ_BITS;

  logic en;
  logic in_acc;

  logic                 clr_active_r;
  logic [IDX_W-1:0]     clr_cnt_r;

  logic                 s1_valid_r;
  rqs_pkg::cmd_t        s1_cmd_r;
  logic [SEQ_BITS-1:0]  s1_tag_r;
  logic [DATA_BITS-1:0] s1_pay_r;

  logic                 s2_valid_r;
  rqs_pkg::cmd_t        s2_cmd_r;
  logic [DATA_BITS-1:0] s2_pay_r;
  logic [IDX_W-1:0]     s2_addr_r;
  logic                 s2_win_r;

  logic                 fwd_hit_r;
  logic [WORD_W-1:0]    fwd_word_r;

  logic [IDX_W-1:0]     head_idx_r;
  logic [IDX_W-1:0]     head_idx_nxt;
  logic [SEQ_BITS-1:0]  head_seq_r;
  logic [SEQ_BITS-1:0]  head_seq_nxt;
  logic                 closed_r;
  logic                 closed_nxt;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic [OUT_W-1:0]     out_data_nxt;

  logic [SEQ_BITS-1:0]  s1_dist;
  logic [CW-1:0]        s1_dist_ext;
  logic                 s1_win;
  logic [IDX_W:0]       s1_sum;
  logic [IDX_W-1:0]     s1_slot;
  logic [IDX_W-1:0]     s1_addr;

  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    s2_word;
  logic                 s2_full;
  logic                 s2_wr;
  logic [WORD_W-1:0]    s2_wdata;
  rqs_pkg::res_ctl_t    s2_res;
  logic [DATA_BITS-1:0] s2_item_data;
  logic [SEQ_BITS-1:0]  s2_item_tag;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = !clr_active_r && (en || !s1_valid_r);
  assign in_acc    = in_tvalid && in_tready;

  // Address of the first stage, taken against the head as the second stage leaves it.
  assign s1_dist     = s1_tag_r - head_seq_nxt;
  assign s1_dist_ext = CW'(s1_dist);
  assign s1_win      = s1_dist_ext < CW'(DEPTH);
  assign s1_sum      = {1'b0, s1_dist_ext[IDX_W-1:0]} + {1'b0, head_idx_nxt};
  assign s1_slot     = (s1_sum >= (IDX_W+1)'(DEPTH)) ?
                       IDX_W'(s1_sum - (IDX_W+1)'(DEPTH)) : s1_sum[IDX_W-1:0];
  assign s1_addr     = (s1_cmd_r == rqs_pkg::CMD_PUSH) ? s1_slot : head_idx_nxt;

  assign s2_word = fwd_hit_r ? fwd_word_r : rd_word;
  assign s2_full = s2_word[WORD_W-1];

  always_comb begin
    s2_res.valid      = s2_valid_r;
    s2_res.status     = rqs_pkg::ST_OK;
    s2_res.item_valid = 1'b0;
    s2_wr             = 1'b0;
    s2_wdata          = {1'b1, s2_pay_r};
    s2_item_data      = '0;
    s2_item_tag       = '0;
    head_idx_nxt      = head_idx_r;
    head_seq_nxt      = head_seq_r;
    closed_nxt        = closed_r;
    if (s2_valid_r) begin
      unique case (s2_cmd_r)
        rqs_pkg::CMD_PUSH: begin
          priority if (closed_r) begin
            s2_res.status = rqs_pkg::ST_CLOSED;
          end else if (!s2_win_r) begin
            s2_res.status = rqs_pkg::ST_WINDOW;
          end else if (s2_full) begin
            s2_res.status = rqs_pkg::ST_OCCUPIED;
          end else begin
            s2_wr = 1'b1;
          end
        end
        rqs_pkg::CMD_POP: begin
          if (s2_full) begin
            s2_res.item_valid = 1'b1;
            s2_item_data      = s2_word[DATA_BITS-1:0];
            s2_item_tag       = head_seq_r;
            s2_wr             = 1'b1;
            s2_wdata          = {1'b0, s2_word[DATA_BITS-1:0]};
            head_idx_nxt      = (head_idx_r == IDX_W'(DEPTH - 1)) ? '0 : head_idx_r + 1'b1;
            head_seq_nxt      = head_seq_r + 1'b1;
          end else if (closed_r) begin
            s2_res.status = rqs_pkg::ST_CLOSED;
          end else begin
            s2_res.status = rqs_pkg::ST_EMPTY;
          end
        end
        rqs_pkg::CMD_CLOSE: begin
          closed_nxt = 1'b1;
        end
        rqs_pkg::CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data_nxt = OUT_W'({s2_item_tag, s2_item_data, s2_res.item_valid, s2_res.status});

  assign ram_we    = clr_active_r || (en && s2_wr);
  assign ram_waddr = clr_active_r ? clr_cnt_r : s2_addr_r;
  assign ram_wdata = clr_active_r ? '0 : s2_wdata;

  rqs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (s1_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_hit_r    <= 1'b0;
      head_idx_r   <= '0;
      head_seq_r   <= '0;
      closed_r     <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (en || !s1_valid_r) begin
        s1_valid_r <= in_acc;
      end
      if (en) begin
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
        fwd_hit_r   <= s2_wr && (s2_addr_r == s1_addr);
        head_idx_r  <= head_idx_nxt;
        head_seq_r  <= head_seq_nxt;
        closed_r    <= closed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en || !s1_valid_r) begin
      s1_cmd_r <= rqs_pkg::cmd_t'(in_tdata[rqs_pkg::CMD_W-1:0]);
      s1_tag_r <= in_tdata[TAG_LO +: SEQ_BITS];
      s1_pay_r <= in_tdata[PAY_LO +: DATA_BITS];
    end
    if (en) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_pay_r   <= s1_pay_r;
      s2_addr_r  <= s1_addr;
      s2_win_r   <= s1_win;
      fwd_word_r <= s2_wdata;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_item_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[rqs_pkg::STATUS_W] |->
      out_tdata[rqs_pkg::STATUS_W-1:0] == rqs_pkg::ST_OK)
    else $error("delivered item without ok status");

  a_head_step : assert property (@(posedge clk) disable iff (!rst_n)
    en && s2_res.valid && s2_res.item_valid |=>
      head_seq_r == $past(head_seq_r) + 1'b1)
    else $error("head sequence did not advance on a pop");

  a_clear_idle : assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !s2_valid_r && !out_valid_r)
    else $error("command in flight during slot clearing");

endmodule
